### hdl/opbd_pkg.sv
// Shared types and constants of the optical pulse beat detector.
`timescale 1ns / 1ps
`default_nettype none
package opbd_pkg;
   localparam int WINDOW_LEN  = 25;
   localparam int SAMPLE_BITS = 24;
   localparam int IDX_BITS    = $clog2(WINDOW_LEN);
   localparam int DVD_BITS    = 34;
   localparam int DVS_BITS    = 32;
   localparam int CNT_BITS    = $clog2(DVD_BITS + 1);
   localparam logic [9:0] LEVEL_FULL = 10'd1000;
   localparam logic [7:0] RATE_MAX   = 8'd255;

   localparam logic [1:0] CMD_RED  = 2'd0;
   localparam logic [1:0] CMD_IR   = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   localparam logic [2:0] REG_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_RED_LEVEL = 3'd1;
   localparam logic [2:0] REG_IR_LEVEL  = 3'd2;
   localparam logic [2:0] REG_TPM       = 3'd3;
   localparam logic [2:0] REG_CWT       = 3'd4;
   localparam logic [2:0] REG_SCALE     = 3'd5;

   typedef struct packed {
      logic [9:0]             pulse_threshold;
      logic [SAMPLE_BITS-1:0] red_present_level;
      logic [SAMPLE_BITS-1:0] ir_present_level;
      logic [23:0]            ticks_per_minute;
      logic [23:0]            count_window_ticks;
      logic [5:0]             count_scale;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             cmd;
      logic [SAMPLE_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic [7:0] bpm_from_count;
      logic [7:0] bpm_from_period;
      logic [9:0] level;
      logic       finger_present;
      logic       beat;
      logic       pulse;
   } result_type;
endpackage
`default_nettype wire

### hdl/opbd_front.sv
// Front queue that accepts requests and hands them to the back end.
`timescale 1ns / 1ps
`default_nettype none
module opbd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire opbd_pkg::item_type in_item,
   output logic                    out_valid,
   input  wire logic               out_pop,
   output opbd_pkg::item_type      out_item
);
   import opbd_pkg::*;
   item_type   slot_ff [2];
   item_type   slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       push;

   assign in_ready  = (count_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = slot_ff[0];

   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (out_pop && out_valid) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         slot_in[count_in[0]] = in_item;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

### hdl/opbd_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module opbd_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [opbd_pkg::DVD_BITS-1:0] dividend,
   input  wire logic [opbd_pkg::DVS_BITS-1:0] divisor,
   output logic                               done,
   output logic [opbd_pkg::DVD_BITS-1:0]      quotient
);
   import opbd_pkg::*;
   logic [DVS_BITS-1:0] rem_ff, dvs_ff;
   logic [DVD_BITS-1:0] dvd_ff, q_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                busy_ff, done_ff;
   logic [DVS_BITS:0]   trial;
   logic                fits;

   assign trial    = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign fits     = (trial >= {1'b0, dvs_ff});
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvs_ff <= divisor;
         dvd_ff <= dividend;
         q_ff   <= '0;
         cnt_ff <= CNT_BITS'(DVD_BITS);
      end else if (busy_ff) begin
         rem_ff <= fits ? DVS_BITS'(trial - {1'b0, dvs_ff}) : DVS_BITS'(trial);
         dvd_ff <= {dvd_ff[DVD_BITS-2:0], 1'b0};
         q_ff   <= {q_ff[DVD_BITS-2:0], fits};
         cnt_ff <= cnt_ff - CNT_BITS'(1);
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_BITS'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

### hdl/opbd_back.sv
// Back end: IR window, level scan, beat and rate logic, result register.
`timescale 1ns / 1ps
`default_nettype none
module opbd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire opbd_pkg::cfg_type    cfg,
   input  wire logic                 in_valid,
   output logic                      in_pop,
   input  wire opbd_pkg::item_type   in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output opbd_pkg::result_type      out_result
);
   import opbd_pkg::*;
   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001, S_SCAN = 8'b00000010, S_DIVL = 8'b00000100,
      S_EDGE = 8'b00001000, S_DIVP = 8'b00010000, S_WIN  = 8'b00100000,
      S_OUT  = 8'b01000000, S_SPAN = 8'b10000000
   } state_type;

   state_type              state_ff;
   logic [SAMPLE_BITS-1:0] win_ff [WINDOW_LEN];
   logic [SAMPLE_BITS-1:0] red_ff, ir_ff, lo_ff, hi_ff, cur;
   logic [IDX_BITS-1:0]    idx_ff;
   logic [9:0]             level_ff;
   logic                   prev_ff, beat_ff, now_pulse, finger;
   logic [31:0]            time_ff, last_ff, start_ff, period;
   logic [7:0]             beats_ff, prate_ff, crate_ff;
   logic [13:0]            cprod;
   logic                   div_start, div_done;
   logic [DVD_BITS-1:0]    div_dvd, div_q;
   logic [DVS_BITS-1:0]    div_dvs;
   result_type             res_ff;
   logic                   rvalid_ff;

   assign cur       = win_ff[idx_ff];
   assign now_pulse = (level_ff > cfg.pulse_threshold);
   assign period    = time_ff - last_ff;
   assign finger    = (red_ff > cfg.red_present_level) && (ir_ff > cfg.ir_present_level);
   assign cprod     = beats_ff * cfg.count_scale;
   assign in_pop    = (state_ff == S_IDLE) && in_valid;
   assign out_valid  = rvalid_ff;
   assign out_result = res_ff;

   always_comb begin
      div_start = 1'b0;
      div_dvd   = DVD_BITS'(win_ff[0] - lo_ff) * DVD_BITS'(LEVEL_FULL);
      div_dvs   = DVS_BITS'(hi_ff - lo_ff);
      if (state_ff == S_SPAN) begin
         div_start = (hi_ff != lo_ff);
      end else if (state_ff == S_EDGE) begin
         div_dvd   = DVD_BITS'(cfg.ticks_per_minute);
         div_dvs   = period;
         div_start = now_pulse && !prev_ff && (period != 32'd0);
      end
   end

   opbd_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dvd),
      .divisor(div_dvs), .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         for (int i = 0; i < WINDOW_LEN; i++) win_ff[i] <= '0;
         red_ff    <= '0;
         ir_ff     <= '0;
         level_ff  <= '0;
         prev_ff   <= 1'b0;
         beat_ff   <= 1'b0;
         time_ff   <= '0;
         last_ff   <= '0;
         start_ff  <= '0;
         beats_ff  <= '0;
         prate_ff  <= '0;
         crate_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && (!rvalid_ff || out_ready)) begin
            rvalid_ff <= 1'b1;
         end else if (out_ready) begin
            rvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (in_valid) begin
                  beat_ff <= 1'b0;
                  case (in_item.cmd)
                     CMD_RED: begin
                        red_ff   <= in_item.sample;
                        state_ff <= S_OUT;
                     end
                     CMD_IR: begin
                        for (int i = 1; i < WINDOW_LEN; i++) win_ff[i] <= win_ff[i-1];
                        win_ff[0] <= in_item.sample;
                        ir_ff     <= in_item.sample;
                        lo_ff     <= in_item.sample;
                        hi_ff     <= in_item.sample;
                        idx_ff    <= IDX_BITS'(1);
                        state_ff  <= S_SCAN;
                     end
                     CMD_TICK: begin
                        time_ff  <= time_ff + 32'd1;
                        state_ff <= S_OUT;
                        if (!finger) begin
                           for (int i = 0; i < WINDOW_LEN; i++) win_ff[i] <= '0;
                        end
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_SCAN: begin
               if (cur < lo_ff) lo_ff <= cur;
               if (cur > hi_ff) hi_ff <= cur;
               if (idx_ff == IDX_BITS'(WINDOW_LEN - 1)) begin
                  state_ff <= S_SPAN;
               end else begin
                  idx_ff <= idx_ff + IDX_BITS'(1);
               end
            end
            S_SPAN: begin
               if (hi_ff == lo_ff) begin
                  level_ff <= '0;
                  state_ff <= S_EDGE;
               end else begin
                  state_ff <= S_DIVL;
               end
            end
            S_DIVL: begin
               if (div_done) begin
                  level_ff <= div_q[9:0];
                  state_ff <= S_EDGE;
               end
            end
            S_EDGE: begin
               prev_ff <= now_pulse;
               if (now_pulse && !prev_ff) begin
                  beat_ff <= 1'b1;
                  last_ff <= time_ff;
                  if (beats_ff != RATE_MAX) beats_ff <= beats_ff + 8'd1;
                  if (period == 32'd0) begin
                     prate_ff <= RATE_MAX;
                     state_ff <= S_WIN;
                  end else begin
                     state_ff <= S_DIVP;
                  end
               end else begin
                  state_ff <= S_WIN;
               end
            end
            S_DIVP: begin
               if (div_done) begin
                  prate_ff <= (div_q > DVD_BITS'(RATE_MAX)) ? RATE_MAX : div_q[7:0];
                  state_ff <= S_WIN;
               end
            end
            S_WIN: begin
               if ((time_ff - start_ff) > 32'(cfg.count_window_ticks)) begin
                  crate_ff <= (cprod > 14'(RATE_MAX)) ? RATE_MAX : cprod[7:0];
                  beats_ff <= '0;
                  start_ff <= time_ff;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rvalid_ff || out_ready) begin
                  res_ff.pulse           <= prev_ff;
                  res_ff.beat            <= beat_ff;
                  res_ff.finger_present  <= finger;
                  res_ff.level           <= level_ff;
                  res_ff.bpm_from_period <= prate_ff;
                  res_ff.bpm_from_count  <= crate_ff;
                  state_ff               <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

### hdl/optical_pulse_beat_detector_top.sv
// Top level of the optical pulse beat detector with its register port.
//
// Requests enter on req_ (tuser carries the command, tdata the sample) and
// each request yields exactly one result on rsp_, in order.
// A red sample, tick or unused command goes straight to the result stage.
// An IR sample passes through a min/max scan of the window and a span
// check, then a divider pass for the level, plus a second divider pass
// on a beat for the period rate. A zero window span skips the level
// division. The single shared divider serves both divisions; one request
// is worked on at a time.
// A two-entry request queue lets requests arrive while the back end works,
// and a result register lets the back end finish while rsp_ is stalled.
// When rsp_tready is low, the result holds and the queue fills, after
// which req_tready drops.
// Synchronous reset clears the window, timers, rates and queue and sets the
// registers to their default values. The user must write registers over
// csr_ only while no request is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module optical_pulse_beat_detector_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // sample[23:0]
   input  wire logic [1:0]  req_tuser,   // cmd[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pulse[0], beat[1], finger_present[2], level[12:3], bpm_from_period[20:13],
   // bpm_from_count[28:21], zero[31:29]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import opbd_pkg::*;
   cfg_type    cfg_ff;
   item_type   req_item, q_item;
   result_type result;
   logic       q_valid, q_pop;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign req_item   = '{cmd: req_tuser, sample: req_tdata};
   assign rsp_tdata  = {3'b000, result};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_threshold    <= 10'd600;
         cfg_ff.red_present_level  <= 24'd200000;
         cfg_ff.ir_present_level   <= 24'd600000;
         cfg_ff.ticks_per_minute   <= 24'd60000;
         cfg_ff.count_window_ticks <= 24'd15000;
         cfg_ff.count_scale        <= 6'd4;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx)
            REG_THRESHOLD: cfg_ff.pulse_threshold    <= csr_pwdata[9:0];
            REG_RED_LEVEL: cfg_ff.red_present_level  <= csr_pwdata[23:0];
            REG_IR_LEVEL:  cfg_ff.ir_present_level   <= csr_pwdata[23:0];
            REG_TPM:       cfg_ff.ticks_per_minute   <= csr_pwdata[23:0];
            REG_CWT:       cfg_ff.count_window_ticks <= csr_pwdata[23:0];
            REG_SCALE:     cfg_ff.count_scale        <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_THRESHOLD: csr_prdata = 32'(cfg_ff.pulse_threshold);
         REG_RED_LEVEL: csr_prdata = 32'(cfg_ff.red_present_level);
         REG_IR_LEVEL:  csr_prdata = 32'(cfg_ff.ir_present_level);
         REG_TPM:       csr_prdata = 32'(cfg_ff.ticks_per_minute);
         REG_CWT:       csr_prdata = 32'(cfg_ff.count_window_ticks);
         REG_SCALE:     csr_prdata = 32'(cfg_ff.count_scale);
         default:       csr_prdata = '0;
      endcase
   end

   opbd_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(req_item), .out_valid(q_valid), .out_pop(q_pop), .out_item(q_item)
   );

   opbd_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .in_valid(q_valid), .in_pop(q_pop),
      .in_item(q_item), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_result(result)
   );
endmodule
`default_nettype wire

### hdl/opbd_checker.sv
// Port-level checker for the optical pulse beat detector and its bind.
`timescale 1ns / 1ps
`default_nettype none
module opbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("beat without pulse");
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[12:3] <= 10'd1000)
      else $error("level out of range");
endmodule

bind optical_pulse_beat_detector_top opbd_checker u_opbd_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the optical pulse beat detector top level.
`timescale 1ns / 1ps
module testbench;
   import opbd_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [23:0] SAMPLE_TOP = 24'hFFFFFF;

   optical_pulse_beat_detector_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // Shadow copy of the detector state and registers.
   logic [23:0] ir_hist [WINDOW_LEN];
   logic [23:0] red_now, ir_now;
   logic [9:0]  level_now;
   logic        pulse_was;
   logic [31:0] tick_count, last_beat_tick, count_start_tick;
   logic [7:0]  window_beats, rate_by_period, rate_by_count;
   cfg_type     regs;

   result_type  pending_results [$];
   int          mismatches;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("optical_pulse_beat_detector_top verification failed");
      $finish;
   end

   function automatic logic finger_on();
      return red_now > regs.red_present_level && ir_now > regs.ir_present_level;
   endfunction

   task automatic detect_step(input logic [1:0] cmd, input logic [23:0] smp,
                              output result_type res);
      logic [23:0] lo, hi;
      logic [63:0] scaled;
      logic [31:0] span, rate, prod;
      logic        beat_now, above;
      beat_now = 1'b0;
      if (cmd == CMD_RED) begin
         red_now = smp;
      end else if (cmd == CMD_IR) begin
         for (int i = WINDOW_LEN - 1; i > 0; i--) ir_hist[i] = ir_hist[i-1];
         ir_hist[0] = smp;
         ir_now = smp;
         lo = ir_hist[0];
         hi = ir_hist[0];
         for (int i = 1; i < WINDOW_LEN; i++) begin
            if (ir_hist[i] < lo) lo = ir_hist[i];
            if (ir_hist[i] > hi) hi = ir_hist[i];
         end
         if (hi == lo) begin
            level_now = '0;
         end else begin
            scaled = (64'(smp) - 64'(lo)) * 64'd1000 / (64'(hi) - 64'(lo));
            level_now = scaled[9:0];
         end
         above = level_now > regs.pulse_threshold;
         if (above && !pulse_was) begin
            span = tick_count - last_beat_tick;
            rate = (span == 0) ? 32'd255 : 32'(regs.ticks_per_minute) / span;
            rate_by_period = (rate > 255) ? 8'd255 : rate[7:0];
            last_beat_tick = tick_count;
            if (window_beats < 8'd255) window_beats++;
            beat_now = 1'b1;
         end
         pulse_was = above;
         if (tick_count - count_start_tick > 32'(regs.count_window_ticks)) begin
            prod = 32'(window_beats) * 32'(regs.count_scale);
            rate_by_count = (prod > 255) ? 8'd255 : prod[7:0];
            window_beats = '0;
            count_start_tick = tick_count;
         end
      end else if (cmd == CMD_TICK) begin
         tick_count++;
         if (!finger_on()) foreach (ir_hist[i]) ir_hist[i] = '0;
      end
      res.pulse = pulse_was;
      res.beat = beat_now;
      res.finger_present = finger_on();
      res.level = level_now;
      res.bpm_from_period = rate_by_period;
      res.bpm_from_count = rate_by_count;
   endtask

   task automatic send_reading(input logic [1:0] cmd, input logic [23:0] smp);
      result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= smp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      detect_step(cmd, smp, res);
      pending_results.push_back(res);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_THRESHOLD: regs.pulse_threshold = val[9:0];
         REG_RED_LEVEL: regs.red_present_level = val[23:0];
         REG_IR_LEVEL:  regs.ir_present_level = val[23:0];
         REG_TPM:       regs.ticks_per_minute = val[23:0];
         REG_CWT:       regs.count_window_ticks = val[23:0];
         REG_SCALE:     regs.count_scale = val[5:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [31:0] thr, red_lvl, ir_lvl, tpm, cwt, scl);
      wait_drained();
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_RED_LEVEL, red_lvl);
      write_reg(REG_IR_LEVEL, ir_lvl);
      write_reg(REG_TPM, tpm);
      write_reg(REG_CWT, cwt);
      write_reg(REG_SCALE, scl);
   endtask

   function automatic logic [23:0] above_level(input logic [23:0] lvl, input int span);
      logic [24:0] v;
      v = 25'(lvl) + 25'd1 + 25'($urandom_range(span));
      return (v > 25'(SAMPLE_TOP)) ? SAMPLE_TOP : v[23:0];
   endfunction

   // Mostly finger-on pulse trains with random shape, plus noise requests.
   task automatic send_pulse_trains(input int count);
      int sent, per, amp, ph;
      logic [23:0] base;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 15) begin
            send_reading(2'($urandom_range(3)), 24'($urandom));
            sent++;
         end else begin
            per = $urandom_range(3, 12);
            amp = $urandom_range(1, 200000);
            base = above_level(regs.ir_present_level, 100000);
            if ($urandom_range(9) == 0) base = 24'($urandom);
            send_reading(CMD_RED, above_level(regs.red_present_level, 500000));
            sent++;
            for (int k = 0; k < 3 * per && sent < count; k++) begin
               ph = k % per;
               send_reading(CMD_IR, (ph < per / 2) ?
                            above_level(base, amp) : base);
               sent++;
               if ($urandom_range(1) == 1) begin
                  send_reading(CMD_TICK, 24'($urandom));
                  sent++;
               end
            end
         end
      end
   endtask

   task automatic test_directed();
      send_reading(CMD_UNUSED, SAMPLE_TOP);
      send_reading(CMD_IR, 24'd0);
      send_reading(CMD_IR, SAMPLE_TOP);
      send_reading(CMD_IR, SAMPLE_TOP);
      send_reading(CMD_RED, 24'd0);
      send_reading(CMD_RED, SAMPLE_TOP);
      send_reading(CMD_TICK, 24'd0);
      send_reading(CMD_IR, 24'd0);
      send_reading(CMD_IR, SAMPLE_TOP);
      send_reading(CMD_TICK, SAMPLE_TOP);
      send_reading(CMD_RED, 24'd0);
      send_reading(CMD_TICK, 24'd0);
      send_reading(CMD_IR, 24'd5);
      send_reading(CMD_UNUSED, 24'd0);
      write_all(1000, 0, 0, 1, 1, 60);
      send_reading(CMD_IR, 24'd0);
      send_reading(CMD_IR, SAMPLE_TOP);
      send_reading(CMD_TICK, 24'd1);
      send_reading(CMD_TICK, 24'd2);
      send_reading(CMD_IR, 24'd0);
      write_all(0, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, SAMPLE_TOP, 1);
      send_reading(CMD_IR, 24'd1);
      send_reading(CMD_IR, 24'd2);
      send_reading(CMD_TICK, 24'd0);
      send_reading(CMD_IR, 24'd3);
   endtask

   task automatic test_count_saturation();
      write_all(600, 0, 0, 60000, SAMPLE_TOP, 60);
      for (int k = 0; k < 260; k++) begin
         send_reading(CMD_IR, 24'd0);
         send_reading(CMD_IR, SAMPLE_TOP);
      end
      write_all(600, 0, 0, 60000, 1, 60);
      send_reading(CMD_TICK, 24'd0);
      send_reading(CMD_TICK, 24'd0);
      send_reading(CMD_IR, 24'd0);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 600;
      for (int k = 0; k < 12; k++) send_reading(CMD_IR, 24'($urandom));
   endtask

   task automatic test_random_phases();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_all(600, 200000, 600000, 60000, 15000, 4);
      send_pulse_trains(72);
      send_idle_pct = 78;
      write_all($urandom_range(300, 700), $urandom_range(1000, 300000),
                $urandom_range(1000, 600000), $urandom_range(100, 5000),
                $urandom_range(5, 40), $urandom_range(1, 60));
      send_pulse_trains(72);
      send_idle_pct = 0;
      recv_stall_pct = 78;
      write_all(0, 0, 0, 1, 1, 60);
      send_pulse_trains(72);
      send_idle_pct = 30;
      recv_stall_pct = 30;
      write_all($urandom_range(1000), $urandom_range(1000, 300000),
                $urandom_range(1000, 600000), $urandom_range(1, 300),
                $urandom_range(1, 20), $urandom_range(1, 60));
      send_pulse_trains(72);
   endtask

   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[28:0];
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %h", rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (got.pulse !== want.pulse || got.beat !== want.beat ||
                got.finger_present !== want.finger_present ||
                got.level !== want.level ||
                got.bpm_from_period !== want.bpm_from_period ||
                got.bpm_from_count !== want.bpm_from_count ||
                rsp_tdata[31:29] !== 3'b000) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected p%0d b%0d f%0d lvl%0d per%0d cnt%0d, got %h",
                           want.pulse, want.beat, want.finger_present, want.level,
                           want.bpm_from_period, want.bpm_from_count, rsp_tdata);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      mismatches = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      foreach (ir_hist[i]) ir_hist[i] = '0;
      red_now = '0;
      ir_now = '0;
      level_now = '0;
      pulse_was = 1'b0;
      tick_count = '0;
      last_beat_tick = '0;
      count_start_tick = '0;
      window_beats = '0;
      rate_by_period = '0;
      rate_by_count = '0;
      regs.pulse_threshold = 10'd600;
      regs.red_present_level = 24'd200000;
      regs.ir_present_level = 24'd600000;
      regs.ticks_per_minute = 24'd60000;
      regs.count_window_ticks = 24'd15000;
      regs.count_scale = 6'd4;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_count_saturation();
      test_backpressure();
      test_random_phases();
      wait_drained();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("optical_pulse_beat_detector_top verification clean");
      end else begin
         $display("optical_pulse_beat_detector_top verification failed");
      end
      $finish;
   end
endmodule
